// File: rtl/drs_pkg.sv
// drs_pkg: shared types and constants of the depth run segmenter
// used by drs_ctrl, drs_dp and depth_run_segmenter; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package drs_pkg;

	localparam int unsigned IDX_W  = 6;
	localparam int unsigned MEAN_W = 16;
	localparam int unsigned CFG_W  = 16;

	localparam logic [CFG_W-1:0] MAX_DEV_RESET = CFG_W'(16);

	// controller to datapath
	typedef struct packed {
		logic accept;     // input transfer: update run state, load divider if needed
		logic load_pend;  // load divider with the one-sample run held back
		logic div_step;   // one quotient bit
		logic out_load;   // move finished result into output register
	} drs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic emit_first; // current input closes a run
		logic pend;       // a second result waits for the divider
		logic div_done;
	} drs_status_t;

endpackage

`default_nettype wire

// File: rtl/drs_dp.sv
// drs_dp: run state, band test, serial divider and output register
// depends on drs_pkg; driven by drs_ctrl through drs_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module drs_dp #(
	parameter int unsigned SCAN_WIDTH = 64,
	parameter int unsigned DEPTH_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [DEPTH_BITS-1:0]      depth,
	input  wire logic                       scan_end,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [drs_pkg::CFG_W-1:0]  max_deviation,
	input  wire drs_pkg::drs_cmd_t          cmd,
	output drs_pkg::drs_status_t            status,
	output logic [drs_pkg::IDX_W-1:0]       start_index,
	output logic [drs_pkg::IDX_W-1:0]       end_index,
	output logic [drs_pkg::MEAN_W-1:0]      mean_depth,
	output logic                            last_cluster
);
	import drs_pkg::*;

	localparam int unsigned POS_W  = $clog2(SCAN_WIDTH);
	localparam int unsigned CNT_W  = $clog2(SCAN_WIDTH + 1);
	localparam int unsigned SUM_W  = DEPTH_BITS + CNT_W;
	localparam int unsigned BAND_W = ((DEPTH_BITS > CFG_W) ? DEPTH_BITS : CFG_W) + 1;
	localparam int unsigned STEP_W = $clog2(SUM_W + 1);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(SCAN_WIDTH - 1);

	logic [CFG_W-1:0]      max_dev_q;
	logic [DEPTH_BITS-1:0] anchor_q;
	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      count_q;
	logic [POS_W-1:0]      start_q;
	logic [POS_W-1:0]      pos_q;

	logic                  pend_q;
	logic [DEPTH_BITS-1:0] pend_depth_q;
	logic [POS_W-1:0]      pend_pos_q;

	// divider and the result fields that travel with it
	logic [SUM_W-1:0]      quo_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W-1:0]      divisor_q;
	logic [STEP_W-1:0]     step_q;
	logic [POS_W-1:0]      em_start_q;
	logic [POS_W-1:0]      em_end_q;
	logic                  em_last_q;

	logic [IDX_W-1:0]      out_start_q;
	logic [IDX_W-1:0]      out_end_q;
	logic [MEAN_W-1:0]     out_mean_q;
	logic                  out_last_q;

	logic                  end_flag;
	logic                  no_run;
	logic                  dev;
	logic [BAND_W-1:0]     ax;
	logic [BAND_W-1:0]     dx;
	logic [BAND_W-1:0]     md;
	logic [SUM_W-1:0]      d_ext;
	logic [SUM_W-1:0]      op_sum;
	logic [CNT_W-1:0]      op_cnt;
	logic [POS_W-1:0]      op_start;
	logic [POS_W-1:0]      op_end;

	logic [CNT_W:0]        partial;
	logic [CNT_W+1:0]      trial;
	logic                  ge;

	logic [POS_W+IDX_W-1:0] start_ext;
	logic [POS_W+IDX_W-1:0] end_ext;
	logic [SUM_W+MEAN_W-1:0] quo_ext;

	assign cfg_ready = 1'b1;

	assign end_flag = scan_end || (pos_q == LAST_POS);
	assign no_run   = (count_q == '0);
	assign ax       = BAND_W'(anchor_q);
	assign dx       = BAND_W'(depth);
	assign md       = BAND_W'(max_dev_q);
	assign dev      = !no_run && ((dx > ax + md) || (ax > dx + md));
	assign d_ext    = SUM_W'(depth);

	// operands of the first result of this input
	always_comb begin
		if (dev) begin
			op_sum   = sum_q;
			op_cnt   = count_q;
			op_start = start_q;
			op_end   = pos_q - POS_W'(1);
		end else if (no_run) begin
			op_sum   = d_ext;
			op_cnt   = CNT_W'(1);
			op_start = pos_q;
			op_end   = pos_q;
		end else begin
			op_sum   = sum_q + d_ext;
			op_cnt   = count_q + CNT_W'(1);
			op_start = start_q;
			op_end   = pos_q;
		end
	end

	assign partial = {rem_q, quo_q[SUM_W-1]};
	assign trial   = {1'b0, partial} - {2'b00, divisor_q};
	assign ge      = !trial[CNT_W+1];

	assign status.emit_first = dev || end_flag;
	assign status.pend       = pend_q;
	assign status.div_done   = (step_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dev_q <= MAX_DEV_RESET;
			anchor_q  <= '0;
			sum_q     <= '0;
			count_q   <= '0;
			start_q   <= '0;
			pos_q     <= '0;
			pend_q    <= 1'b0;
			step_q    <= '0;
		end else begin
			if (cfg_valid) begin
				max_dev_q <= max_deviation;
			end
			if (cmd.accept) begin
				pend_q <= dev && end_flag;
				if (end_flag) begin
					anchor_q <= '0;
					sum_q    <= '0;
					count_q  <= '0;
					start_q  <= '0;
					pos_q    <= '0;
				end else begin
					if (no_run || dev) begin
						anchor_q <= depth;
						sum_q    <= d_ext;
						count_q  <= CNT_W'(1);
						start_q  <= pos_q;
					end else begin
						sum_q   <= sum_q + d_ext;
						count_q <= count_q + CNT_W'(1);
					end
					pos_q <= pos_q + POS_W'(1);
				end
				if (dev || end_flag) begin
					step_q <= STEP_W'(SUM_W);
				end
			end else if (cmd.load_pend) begin
				pend_q <= 1'b0;
				step_q <= STEP_W'(SUM_W);
			end else if (cmd.div_step) begin
				step_q <= step_q - STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pend_depth_q <= depth;
			pend_pos_q   <= pos_q;
			quo_q        <= op_sum;
			rem_q        <= '0;
			divisor_q    <= op_cnt;
			em_start_q   <= op_start;
			em_end_q     <= op_end;
			em_last_q    <= end_flag && !dev;
		end else if (cmd.load_pend) begin
			quo_q      <= SUM_W'(pend_depth_q);
			rem_q      <= '0;
			divisor_q  <= CNT_W'(1);
			em_start_q <= pend_pos_q;
			em_end_q   <= pend_pos_q;
			em_last_q  <= 1'b1;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? trial[CNT_W-1:0] : partial[CNT_W-1:0];
		end
	end

	assign start_ext = {{IDX_W{1'b0}}, em_start_q};
	assign end_ext   = {{IDX_W{1'b0}}, em_end_q};
	assign quo_ext   = {{MEAN_W{1'b0}}, quo_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_start_q <= start_ext[IDX_W-1:0];
			out_end_q   <= end_ext[IDX_W-1:0];
			out_mean_q  <= quo_ext[MEAN_W-1:0];
			out_last_q  <= em_last_q;
		end
	end

	assign start_index  = out_start_q;
	assign end_index    = out_end_q;
	assign mean_depth   = out_mean_q;
	assign last_cluster = out_last_q;

endmodule

`default_nettype wire

// File: rtl/drs_ctrl.sv
// drs_ctrl: sequencing of input transfers, divider runs and result transfers
// depends on drs_pkg; commands drs_dp
`timescale 1ns / 1ps
`default_nettype none

module drs_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire drs_pkg::drs_status_t status,
	output drs_pkg::drs_cmd_t         cmd
);
	import drs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.accept    = 1'b0;
		cmd.load_pend = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.emit_first) begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_HOLD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_HOLD: begin
				// result waits here until the output register frees up
				if (out_free) begin
					cmd.out_load = 1'b1;
					if (status.pend) begin
						cmd.load_pend = 1'b1;
						state_d       = ST_DIV;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwrote a pending output transfer");

	a_no_pend_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !status.pend)
		else $error("second result left behind while idle");

	a_div_done_to_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && status.div_done) |=> (state_q == ST_HOLD))
		else $error("finished division not held for output");

	a_pend_restarts_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_pend |=> (state_q == ST_DIV && !status.div_done))
		else $error("second result did not start the divider");

endmodule

`default_nettype wire

// File: rtl/depth_run_segmenter.sv
// depth_run_segmenter: top level, joins drs_ctrl and drs_dp
// depends on drs_pkg, drs_ctrl, drs_dp
`timescale 1ns / 1ps
`default_nettype none

// Splits the depth samples of a scan line into clusters and reports start
// index, end index and truncated mean depth of each closed cluster. An input
// that closes no cluster leaves the block ready for the next sample. Each
// result comes from a radix-2 divider that produces one quotient bit per
// cycle, and a sample that deviates at the end of a scan gives two results
// back to back. A new sample is taken once the divider has handed its result
// to the output register, even if that result has not yet been transferred.
// max_deviation may be written only while the block is idle.
module depth_run_segmenter #(
	parameter int unsigned SCAN_WIDTH = 64,
	parameter int unsigned DEPTH_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [DEPTH_BITS-1:0]      depth,
	input  wire logic                       scan_end,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [drs_pkg::IDX_W-1:0]       start_index,
	output logic [drs_pkg::IDX_W-1:0]       end_index,
	output logic [drs_pkg::MEAN_W-1:0]      mean_depth,
	output logic                            last_cluster,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [drs_pkg::CFG_W-1:0]  max_deviation
);
	import drs_pkg::*;

	drs_cmd_t    cmd;
	drs_status_t status;

	drs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	drs_dp #(
		.SCAN_WIDTH (SCAN_WIDTH),
		.DEPTH_BITS (DEPTH_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.depth         (depth),
		.scan_end      (scan_end),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.max_deviation (max_deviation),
		.cmd           (cmd),
		.status        (status),
		.start_index   (start_index),
		.end_index     (end_index),
		.mean_depth    (mean_depth),
		.last_cluster  (last_cluster)
	);

endmodule

`default_nettype wire

// File: dv/depth_run_segmenter_tb.sv
// depth_run_segmenter_tb: self-checking testbench for the depth run segmenter
// drives scan lines through valid/ready, predicts clusters in-line, checks every field
// depends on drs_pkg and depth_run_segmenter
`timescale 1ns / 1ps

module depth_run_segmenter_tb;
	import drs_pkg::*;

	localparam int unsigned SCAN_WIDTH      = 64;
	localparam int unsigned DEPTH_BITS      = 16;
	localparam int unsigned CYCLE_LIMIT     = 1000000;
	localparam int unsigned SETTLE_CYCLES   = 60;
	localparam int unsigned DRAIN_LIMIT     = 20000;
	localparam int unsigned ITEMS_PER_PHASE = 220;
	localparam int unsigned NUM_PHASES      = 7;
	localparam int unsigned NUM_ROWS        = 19;

	typedef struct packed {
		logic [IDX_W-1:0]  start_idx;
		logic [IDX_W-1:0]  end_idx;
		logic [MEAN_W-1:0] mean;
		logic              closes_scan;
	} cluster_t;

	typedef struct {
		logic [DEPTH_BITS-1:0] depth;
		logic                  scan_end;
		bit                    typed;
		cluster_t              want;
	} stim_row_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [DEPTH_BITS-1:0] depth;
	logic                  scan_end;
	logic                  out_valid;
	logic                  out_ready;
	logic [IDX_W-1:0]      start_index;
	logic [IDX_W-1:0]      end_index;
	logic [MEAN_W-1:0]     mean_depth;
	logic                  last_cluster;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      max_deviation;

	// typed expectation travels with the sample it belongs to
	logic                  row_typed;
	cluster_t              row_want;

	// predicted block state
	logic [CFG_W-1:0]      band;
	logic [DEPTH_BITS-1:0] anchor;
	logic [21:0]           run_total;
	logic [6:0]            run_len;
	logic [IDX_W-1:0]      run_first;
	logic [IDX_W-1:0]      scan_pos;
	cluster_t              expected_clusters[$];

	int unsigned mismatches;
	int unsigned cycles;
	int unsigned burst_left;
	bit          steady;
	rx_mode_t    rx_mode;
	int unsigned rx_tick;

	stim_row_t directed_rows[NUM_ROWS] = '{
		'{16'd100,   1'b0, 1'b0, '0},
		'{16'd116,   1'b0, 1'b0, '0},
		'{16'd84,    1'b0, 1'b0, '0},
		'{16'd117,   1'b0, 1'b1, '{6'd0, 6'd2, 16'd100, 1'b0}},
		'{16'd0,     1'b1, 1'b1, '{6'd4, 6'd4, 16'd0, 1'b1}},
		'{16'd65535, 1'b1, 1'b1, '{6'd0, 6'd0, 16'd65535, 1'b1}},
		'{16'd0,     1'b0, 1'b0, '0},
		'{16'd65535, 1'b1, 1'b1, '{6'd1, 6'd1, 16'd65535, 1'b1}},
		'{16'd65535, 1'b0, 1'b0, '0},
		'{16'd65519, 1'b0, 1'b0, '0},
		'{16'd65530, 1'b1, 1'b1, '{6'd0, 6'd2, 16'd65528, 1'b1}},
		'{16'd5,     1'b0, 1'b0, '0},
		'{16'd0,     1'b0, 1'b0, '0},
		'{16'd21,    1'b0, 1'b0, '0},
		'{16'd22,    1'b1, 1'b1, '{6'd3, 6'd3, 16'd22, 1'b1}},
		'{16'hAAAA,  1'b0, 1'b0, '0},
		'{16'h5555,  1'b0, 1'b0, '0},
		'{16'h5555,  1'b0, 1'b0, '0},
		'{16'hAAAA,  1'b1, 1'b0, '0}
	};

	int unsigned band_plan[NUM_PHASES] = '{0, 65535, 1, 300, 0, 16, 2000};

	depth_run_segmenter #(
		.SCAN_WIDTH(SCAN_WIDTH),
		.DEPTH_BITS(DEPTH_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.depth        (depth),
		.scan_end     (scan_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.start_index  (start_index),
		.end_index    (end_index),
		.mean_depth   (mean_depth),
		.last_cluster (last_cluster),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.max_deviation(max_deviation)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (mismatches < 50) begin
			$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		end
		mismatches++;
	endtask

	function automatic cluster_t close_run(input logic [IDX_W-1:0] last_pos,
			input logic ends_scan);
		cluster_t c;
		c.start_idx   = run_first;
		c.end_idx     = last_pos;
		c.mean        = (run_len != 0) ? MEAN_W'(run_total / run_len) : '0;
		c.closes_scan = ends_scan;
		return c;
	endfunction

	task automatic start_run(input logic [DEPTH_BITS-1:0] d);
		anchor    = d;
		run_total = 22'(d);
		run_len   = 7'd1;
		run_first = scan_pos;
	endtask

	task automatic segment_sample(input logic [DEPTH_BITS-1:0] d, input logic e,
			input logic typed, input cluster_t want);
		cluster_t found[$];
		logic     ends;
		ends = e || (scan_pos >= IDX_W'(SCAN_WIDTH - 1));
		if (run_len == 0) begin
			start_run(d);
		end else if ({1'b0, d} > {1'b0, anchor} + band ||
				{1'b0, anchor} > {1'b0, d} + band) begin
			found = {found, close_run(scan_pos - 1'b1, 1'b0)};
			start_run(d);
		end else begin
			run_total = run_total + 22'(d);
			run_len   = run_len + 1'b1;
		end
		if (ends) begin
			found = {found, close_run(scan_pos, 1'b1)};
			anchor    = '0;
			run_total = '0;
			run_len   = '0;
			run_first = '0;
			scan_pos  = '0;
		end else begin
			scan_pos = scan_pos + 1'b1;
		end
		if (typed && found.size() > 0) begin
			found[found.size() - 1] = want;
		end
		expected_clusters = {expected_clusters, found};
	endtask

	task automatic check_cluster();
		cluster_t want;
		if (expected_clusters.size() == 0) begin
			report_mismatch("cluster with nothing expected", 32'(mean_depth), 0);
		end else begin
			want = expected_clusters.pop_front();
			if (start_index != want.start_idx)
				report_mismatch("start_index", 32'(start_index), 32'(want.start_idx));
			if (end_index != want.end_idx)
				report_mismatch("end_index", 32'(end_index), 32'(want.end_idx));
			if (mean_depth != want.mean)
				report_mismatch("mean_depth", 32'(mean_depth), 32'(want.mean));
			if (last_cluster != want.closes_scan)
				report_mismatch("last_cluster", 32'(last_cluster),
					32'(want.closes_scan));
		end
	endtask

	// predictor and checker, sampled at the edge where transfers happen
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("depth_run_segmenter_tb failed");
				$finish;
			end else begin
				if (cfg_valid && cfg_ready)
					band = max_deviation;
				if (in_valid && in_ready)
					segment_sample(depth, scan_end, row_typed, row_want);
				if (out_valid && out_ready)
					check_cluster();
			end
		end
	end

	// receiver: the stall pattern is redrawn at random, periodically
	always @(posedge clk) begin
		if (rx_tick % 300 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		rx_tick++;
		case (rx_mode)
			RX_OPEN:     out_ready <= 1'b1;
			RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE:   out_ready <= ($urandom_range(0, 4) == 0);
			RX_PERIODIC: out_ready <= (rx_tick % 8 == 0);
			default:     out_ready <= 1'b1;
		endcase
	end

	task automatic send_sample(input logic [DEPTH_BITS-1:0] d, input logic e,
			input logic typed, input cluster_t want);
		in_valid  <= 1'b1;
		depth     <= d;
		scan_end  <= e;
		row_typed <= typed;
		row_want  <= want;
		do @(posedge clk); while (!in_ready);
		if (!steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// hold the sender until every predicted cluster has been taken
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (expected_clusters.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_band(input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_valid     <= 1'b1;
		max_deviation <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// one scan: samples wander around a level, with jumps and some noise
	task automatic send_scan(input bit force_long, output int unsigned sent);
		int unsigned len;
		int          spread;
		int          level;
		int          v;
		bit          long_scan;
		bit          end_marked;
		long_scan  = force_long || ($urandom_range(0, 15) == 0);
		len        = long_scan ? $urandom_range(60, 80) : $urandom_range(1, 20);
		end_marked = long_scan ? 1'($urandom_range(0, 1)) : 1'b1;
		spread     = int'(band) + int'(band) / 4 + 2;
		level      = $urandom_range(0, 65535);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0:       level = 0;
					1:       level = 65535;
					default: level = $urandom_range(0, 65535);
				endcase
			end
			if ($urandom_range(0, 19) == 0)
				v = $urandom_range(0, 65535);
			else
				v = level + int'($urandom_range(0, 2 * spread)) - spread;
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			send_sample(v[DEPTH_BITS-1:0], (i == len - 1) && end_marked, 1'b0, '0);
		end
		sent = len;
	endtask

	initial begin
		int unsigned phase_items;
		int unsigned scan_items;
		int unsigned waited;
		bit          paused;

		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		depth         = '0;
		scan_end      = 1'b0;
		out_ready     = 1'b0;
		cfg_valid     = 1'b0;
		max_deviation = '0;
		row_typed     = 1'b0;
		row_want      = '0;
		band          = MAX_DEV_RESET;
		anchor        = '0;
		run_total     = '0;
		run_len       = '0;
		run_first     = '0;
		scan_pos      = '0;
		mismatches    = 0;
		cycles        = 0;
		burst_left    = 0;
		steady        = 1'b0;
		rx_mode       = RX_OPEN;
		rx_tick       = 0;
		paused        = 1'b0;
		band_plan[4]  = $urandom_range(2, 5000);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part runs at the reset deviation
		foreach (directed_rows[i])
			send_sample(directed_rows[i].depth, directed_rows[i].scan_end,
				directed_rows[i].typed, directed_rows[i].want);

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_band(CFG_W'(band_plan[p]));
			steady      = (p % 3 == 1);
			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) begin
				send_scan(p == 0 && phase_items == 0, scan_items);
				phase_items += scan_items;
				if (p == 2 && !paused && phase_items > ITEMS_PER_PHASE / 2) begin
					wait_idle();
					paused = 1'b1;
				end
			end
		end

		// close whatever run is still open
		send_sample(16'($urandom_range(0, 65535)), 1'b1, 1'b0, '0);
		in_valid <= 1'b0;

		waited = 0;
		while (expected_clusters.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_clusters.size() != 0)
			report_mismatch("clusters never delivered", 0, expected_clusters.size());

		if (mismatches == 0) begin
			$display("depth_run_segmenter_tb passed");
		end else begin
			$display("depth_run_segmenter_tb failed");
		end
		$finish;
	end

endmodule
